// ===== rtl/core/i2c_master_bit_sequencer_macros.svh =====
// Assertion macros for the I2C master bit sequencer.
// Each check is written as a property with a reporting action. Defining
// NO_ASSERTIONS removes them all.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define I2CBS_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("i2cbs: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define I2CBS_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("i2cbs: next-cycle check failed");

`else

`define I2CBS_ASSERT_IMPL(label, clk, rst, cond, expr)
`define I2CBS_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== rtl/core/i2cbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cbs_pkg;

   localparam int unsigned DELAY_W = 16;
   localparam int unsigned CSR_INDEX_W = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_TICKS     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_PHASE_TICKS = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_HIGH_TICKS  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT     = 8'd3;

   localparam logic [DELAY_W-1:0] PHASE_TICKS_RESET     = 16'd10;
   localparam logic [DELAY_W-1:0] ACK_PHASE_TICKS_RESET = 16'd4;
   localparam logic [DELAY_W-1:0] ACK_HIGH_TICKS_RESET  = 16'd6;
   localparam logic [DELAY_W-1:0] ACK_TIMEOUT_RESET     = 16'd250;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_START    = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_WRITE    = 3'd3,
      CMD_READ     = 3'd4,
      CMD_WAIT_ACK = 3'd5,
      CMD_ACK      = 3'd6,
      CMD_NACK     = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [DELAY_W-1:0] phase_ticks;
      logic [DELAY_W-1:0] ack_phase_ticks;
      logic [DELAY_W-1:0] ack_high_ticks;
      logic [DELAY_W-1:0] ack_timeout;
   } cfg_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  tx_byte;
      logic        sda_in;
   } tick_type;

   typedef struct packed {
      logic        scl_level;
      logic        sda_release;
      logic        busy_res;
      logic        done_res;
      logic [7:0]  rx_byte;
      logic        ack_missing;
   } result_type;

   // A delay register of zero behaves as a delay of one tick.
   function automatic logic [DELAY_W-1:0] wait_len(input logic [DELAY_W-1:0] n);
      return (n == '0) ? DELAY_W'(1) : n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/i2cbs_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_csr
   import i2cbs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [CSR_INDEX_W-1:0] wr_index,
   input  wire logic [DELAY_W-1:0]     wr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_PHASE_TICKS:     cfg_in.phase_ticks     = wr_data;
            CSR_ACK_PHASE_TICKS: cfg_in.ack_phase_ticks = wr_data;
            CSR_ACK_HIGH_TICKS:  cfg_in.ack_high_ticks  = wr_data;
            CSR_ACK_TIMEOUT:     cfg_in.ack_timeout     = wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks     <= PHASE_TICKS_RESET;
         cfg_ff.ack_phase_ticks <= ACK_PHASE_TICKS_RESET;
         cfg_ff.ack_high_ticks  <= ACK_HIGH_TICKS_RESET;
         cfg_ff.ack_timeout     <= ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/i2cbs_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_seq
   import i2cbs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step_en,
   input  wire tick_type tick,
   input  wire cfg_type  cfg,
   output result_type    result
);

   typedef enum logic [16:0] {
      ST_IDLE    = 17'b00000000000000001,
      ST_ST_B    = 17'b00000000000000010,
      ST_ST_C    = 17'b00000000000000100,
      ST_ST_D    = 17'b00000000000001000,
      ST_ST_E    = 17'b00000000000010000,
      ST_SP_B    = 17'b00000000000100000,
      ST_SP_C    = 17'b00000000001000000,
      ST_SP_D    = 17'b00000000010000000,
      ST_WR_HI   = 17'b00000000100000000,
      ST_WR_LO   = 17'b00000001000000000,
      ST_WR_NX   = 17'b00000010000000000,
      ST_RD_HI   = 17'b00000100000000000,
      ST_RD_SMP  = 17'b00001000000000000,
      ST_WA_HI   = 17'b00010000000000000,
      ST_WA_POLL = 17'b00100000000000000,
      ST_K_HI    = 17'b01000000000000000,
      ST_K_LO    = 17'b10000000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [DELAY_W-1:0] phase_count_ff, phase_count_in;
   logic [3:0]         bit_index_ff, bit_index_in;
   logic [7:0]         shift_byte_ff, shift_byte_in;
   logic [7:0]         rx_byte_ff, rx_byte_in;
   logic [DELAY_W-1:0] timeout_count_ff, timeout_count_in;
   logic               scl_drive_ff, scl_drive_in;
   logic               sda_drive_ff, sda_drive_in;
   logic               ack_flag_ff, ack_flag_in;

   logic [DELAY_W-1:0] count_dec;
   logic [3:0]         bit_inc;
   logic [7:0]         shift_next;
   logic               do_poll;
   logic               done;

   assign count_dec  = phase_count_ff - DELAY_W'(1);
   assign bit_inc    = bit_index_ff + 4'd1;
   assign shift_next = {shift_byte_ff[6:0], 1'b0};

   always_comb begin
      state_in         = state_ff;
      phase_count_in   = phase_count_ff;
      bit_index_in     = bit_index_ff;
      shift_byte_in    = shift_byte_ff;
      rx_byte_in       = rx_byte_ff;
      timeout_count_in = timeout_count_ff;
      scl_drive_in     = scl_drive_ff;
      sda_drive_in     = sda_drive_ff;
      ack_flag_in      = ack_flag_ff;
      do_poll          = 1'b0;
      done             = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            case (tick.command)
               CMD_START: begin
                  sda_drive_in   = 1'b1;
                  phase_count_in = wait_len(cfg.phase_ticks);
                  state_in       = ST_ST_B;
               end
               CMD_STOP: begin
                  sda_drive_in   = 1'b0;
                  phase_count_in = wait_len(cfg.phase_ticks);
                  state_in       = ST_SP_B;
               end
               CMD_WRITE: begin
                  shift_byte_in  = tick.tx_byte;
                  bit_index_in   = '0;
                  sda_drive_in   = tick.tx_byte[7];
                  phase_count_in = wait_len(cfg.phase_ticks);
                  state_in       = ST_WR_HI;
               end
               CMD_READ: begin
                  shift_byte_in  = '0;
                  bit_index_in   = '0;
                  sda_drive_in   = 1'b1;
                  phase_count_in = wait_len(cfg.phase_ticks);
                  state_in       = ST_RD_HI;
               end
               CMD_WAIT_ACK: begin
                  ack_flag_in      = 1'b0;
                  timeout_count_in = '0;
                  sda_drive_in     = 1'b1;
                  phase_count_in   = wait_len(cfg.ack_phase_ticks);
                  state_in         = ST_WA_HI;
               end
               CMD_ACK: begin
                  scl_drive_in   = 1'b0;
                  sda_drive_in   = 1'b0;
                  bit_index_in   = '0;
                  phase_count_in = wait_len(cfg.ack_phase_ticks);
                  state_in       = ST_K_HI;
               end
               CMD_NACK: begin
                  sda_drive_in   = 1'b1;
                  bit_index_in   = 4'd1;
                  phase_count_in = wait_len(cfg.phase_ticks);
                  state_in       = ST_K_HI;
               end
               default: ;
            endcase
         end
         ST_WA_POLL: begin
            if (phase_count_ff == '0) begin
               do_poll = 1'b1;
            end else begin
               phase_count_in = count_dec;
               do_poll        = (count_dec == '0);
            end
         end
         ST_K_LO: begin
            phase_count_in = count_dec;
            if (count_dec == '0) begin
               scl_drive_in = 1'b0;
               done         = 1'b1;
            end
         end
         default: begin
            phase_count_in = count_dec;
            if (count_dec == '0) begin
               case (state_ff)
                  ST_ST_B: begin
                     scl_drive_in   = 1'b1;
                     phase_count_in = wait_len(cfg.phase_ticks);
                     state_in       = ST_ST_C;
                  end
                  ST_ST_C: begin
                     sda_drive_in   = 1'b0;
                     phase_count_in = wait_len(cfg.phase_ticks);
                     state_in       = ST_ST_D;
                  end
                  ST_ST_D: begin
                     scl_drive_in   = 1'b0;
                     phase_count_in = wait_len(cfg.phase_ticks);
                     state_in       = ST_ST_E;
                  end
                  ST_SP_B: begin
                     scl_drive_in   = 1'b1;
                     phase_count_in = wait_len(cfg.phase_ticks);
                     state_in       = ST_SP_C;
                  end
                  ST_SP_C: begin
                     sda_drive_in   = 1'b1;
                     phase_count_in = wait_len(cfg.phase_ticks);
                     state_in       = ST_SP_D;
                  end
                  ST_WR_HI: begin
                     scl_drive_in   = 1'b1;
                     phase_count_in = wait_len(cfg.phase_ticks);
                     state_in       = ST_WR_LO;
                  end
                  ST_WR_LO: begin
                     scl_drive_in   = 1'b0;
                     phase_count_in = wait_len(cfg.phase_ticks);
                     state_in       = ST_WR_NX;
                  end
                  ST_WR_NX: begin
                     bit_index_in = bit_inc;
                     if (bit_inc >= 4'd8) begin
                        done = 1'b1;
                     end else begin
                        shift_byte_in  = shift_next;
                        sda_drive_in   = shift_next[7];
                        phase_count_in = wait_len(cfg.phase_ticks);
                        state_in       = ST_WR_HI;
                     end
                  end
                  ST_RD_HI: begin
                     if (bit_index_ff >= 4'd8) begin
                        rx_byte_in = shift_byte_ff;
                        done       = 1'b1;
                     end else begin
                        scl_drive_in   = 1'b1;
                        phase_count_in = wait_len(cfg.phase_ticks);
                        state_in       = ST_RD_SMP;
                     end
                  end
                  ST_RD_SMP: begin
                     if (tick.sda_in) begin
                        shift_byte_in = shift_byte_ff | (8'h80 >> bit_index_ff[2:0]);
                     end
                     scl_drive_in   = 1'b0;
                     bit_index_in   = bit_inc;
                     phase_count_in = wait_len(cfg.phase_ticks);
                     state_in       = ST_RD_HI;
                  end
                  ST_WA_HI: begin
                     scl_drive_in   = 1'b1;
                     phase_count_in = wait_len(cfg.ack_high_ticks);
                     state_in       = ST_WA_POLL;
                  end
                  ST_K_HI: begin
                     scl_drive_in   = 1'b1;
                     phase_count_in = (bit_index_ff != '0) ? wait_len(cfg.phase_ticks)
                                                           : wait_len(cfg.ack_phase_ticks);
                     state_in       = ST_K_LO;
                  end
                  default: done = 1'b1;
               endcase
            end
         end
      endcase

      // Ack poll: a low SDA ends the command, a long run of highs forces a stop.
      if (do_poll) begin
         if (!tick.sda_in) begin
            scl_drive_in = 1'b0;
            done         = 1'b1;
         end else if (timeout_count_ff >= cfg.ack_timeout) begin
            ack_flag_in    = 1'b1;
            sda_drive_in   = 1'b0;
            phase_count_in = wait_len(cfg.phase_ticks);
            state_in       = ST_SP_B;
         end else begin
            timeout_count_in = timeout_count_ff + DELAY_W'(1);
         end
      end

      if (done) begin
         state_in       = ST_IDLE;
         phase_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         phase_count_ff   <= '0;
         bit_index_ff     <= '0;
         shift_byte_ff    <= '0;
         rx_byte_ff       <= '0;
         timeout_count_ff <= '0;
         scl_drive_ff     <= 1'b1;
         sda_drive_ff     <= 1'b1;
         ack_flag_ff      <= 1'b0;
      end else if (step_en) begin
         state_ff         <= state_in;
         phase_count_ff   <= phase_count_in;
         bit_index_ff     <= bit_index_in;
         shift_byte_ff    <= shift_byte_in;
         rx_byte_ff       <= rx_byte_in;
         timeout_count_ff <= timeout_count_in;
         scl_drive_ff     <= scl_drive_in;
         sda_drive_ff     <= sda_drive_in;
         ack_flag_ff      <= ack_flag_in;
      end
   end

   always_comb begin
      result.scl_level   = scl_drive_in;
      result.sda_release = sda_drive_in;
      result.busy_res    = (state_in != ST_IDLE);
      result.done_res    = done;
      result.rx_byte     = rx_byte_in;
      result.ack_missing = ack_flag_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_bit_sequencer.sv =====
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-------------------------------------------
// req_      | in        | req_tvalid/tready   | tuser: command; tdata: tx_byte, sda_in
// rsp_      | out       | rsp_tvalid/tready   | tdata: line levels, busy, done, rx, ack flag
// csr_      | in        | csr_valid/ready     | csr_index, csr_data (16-bit delay registers)
//
// Each tick item is captured in an input register and then goes through the sequencer
// step logic into the result register, which offers it; one item per cycle is sustained
// while the result side keeps taking items. The sequencer state advances exactly when
// its result is written. Reset is synchronous and active high; it returns the lines to
// released, the sequencer to idle and the delay registers to their defaults. A stalled
// result holds the input register, and the input side accepts again once the result
// register can take the pending item.
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_bit_sequencer_macros.svh"

module i2c_master_bit_sequencer
   import i2cbs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [15:0]            req_tdata,  // [7:0] tx_byte, [8] sda_in, rest zero
   input  wire logic [2:0]             req_tuser,  // [2:0] command

   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [15:0]            rsp_tdata,  // [0] scl_level, [1] sda_release,
                                                    // [2] busy_res, [3] done_res,
                                                    // [11:4] rx_byte, [12] ack_missing

   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DELAY_W-1:0]     csr_data
);

   logic       in_valid_ff, in_valid_in;
   tick_type   in_tick_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   logic       req_accept;
   logic       step;
   cfg_type    cfg;
   result_type step_result;

   // Writes must arrive only while idle, which the block does not enforce; the port is always ready.
   assign csr_ready = 1'b1;

   i2cbs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // The held tick advances when the result register is empty or being drained.
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_tick_ff.command <= cmd_type'(req_tuser);
         in_tick_ff.tx_byte <= req_tdata[7:0];
         in_tick_ff.sda_in  <= req_tdata[8];
      end
      if (step) begin
         rsp_data_ff <= step_result;
      end
   end

   i2cbs_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .tick    (in_tick_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_data_ff.ack_missing,
                        rsp_data_ff.rx_byte,
                        rsp_data_ff.done_res,
                        rsp_data_ff.busy_res,
                        rsp_data_ff.sda_release,
                        rsp_data_ff.scl_level};

   // A finished command always leaves the sequencer idle.
   `I2CBS_ASSERT_IMPL(a_done_not_busy, clock, reset,
                      step && step_result.done_res, !step_result.busy_res)

   // Every step lands an item in the result register.
   `I2CBS_ASSERT_NEXT(a_step_fills_rsp, clock, reset, step, rsp_valid_ff)

   // A held tick that cannot advance stays in the input register.
   `I2CBS_ASSERT_NEXT(a_tick_held, clock, reset, in_valid_ff && !step, in_valid_ff)

endmodule

`default_nettype wire

// ===== test/i2c_master_bit_sequencer_tb.sv =====
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_tb;
   import i2cbs_pkg::*;

   // Phases of the line sequencer as the predictor tracks them. The ack and
   // nack generators share the high phase and then finish with a plain count
   // down that is marked by ack_low_pending instead of a phase of its own.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_B,
      PH_START_C,
      PH_START_D,
      PH_START_E,
      PH_STOP_B,
      PH_STOP_C,
      PH_STOP_D,
      PH_WR_HIGH,
      PH_WR_LOW,
      PH_WR_NEXT,
      PH_RD_HIGH,
      PH_RD_SAMPLE,
      PH_ACK_HIGH,
      PH_ACK_POLL,
      PH_GEN_HIGH
   } line_phase_type;

   // An index past the last register; writes to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_INDEX    = 8'hFF;
   localparam int unsigned RSP_HOLD_CYCLES = 400;
   localparam int unsigned MAX_PRINTED     = 40;

   logic clock;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata  = '0;  // [7:0] tx_byte, [8] sda_in, rest zero
   logic [2:0]             req_tuser  = '0;  // [2:0] command

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;        // [0] scl_level, [1] sda_release,
                                             // [2] busy_res, [3] done_res,
                                             // [11:4] rx_byte, [12] ack_missing

   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [DELAY_W-1:0]     csr_data   = '0;

   i2c_master_bit_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the delay registers and of the
   // sequencer, advanced once for every item the block accepts.
   // ---------------------------------------------------------------------
   cfg_type        cfg;
   line_phase_type seq_st;
   logic [15:0]    ph_cnt;
   logic [3:0]     bit_idx;
   logic [7:0]     shifter;
   logic [7:0]     rx_hold;
   logic [15:0]    to_cnt;
   logic           scl_q;
   logic           sda_q;
   logic           ack_q;
   logic           ack_low_pending;

   // Expected line levels and flags, oldest first, one entry per accepted item.
   result_type  expected_levels[$];

   // Commands still to be issued for the current well-formed bus transfer.
   cmd_type     plan[$];

   int          mismatch_count = 0;
   bit          gaps_on = 1'b1;       // random idling on both sides
   bit          hold_pending = 1'b0;  // asks the receiver for one long hold-off
   int          sda_high_left = -1;   // SDA-high ticks left in a wait ack, -1 random

   function automatic void reset_model();
      cfg.phase_ticks     = PHASE_TICKS_RESET;
      cfg.ack_phase_ticks = ACK_PHASE_TICKS_RESET;
      cfg.ack_high_ticks  = ACK_HIGH_TICKS_RESET;
      cfg.ack_timeout     = ACK_TIMEOUT_RESET;
      seq_st          = PH_IDLE;
      ph_cnt          = '0;
      bit_idx         = '0;
      shifter         = '0;
      rx_hold         = '0;
      to_cnt          = '0;
      scl_q           = 1'b1;
      sda_q           = 1'b1;
      ack_q           = 1'b0;
      ack_low_pending = 1'b0;
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [DELAY_W-1:0] val);
      case (idx)
         CSR_PHASE_TICKS:     cfg.phase_ticks     = val;
         CSR_ACK_PHASE_TICKS: cfg.ack_phase_ticks = val;
         CSR_ACK_HIGH_TICKS:  cfg.ack_high_ticks  = val;
         CSR_ACK_TIMEOUT:     cfg.ack_timeout     = val;
         default: ;
      endcase
   endfunction

   // A delay of zero counts as one tick.
   function automatic logic [15:0] ticks_of(input logic [DELAY_W-1:0] n);
      return (n == '0) ? 16'd1 : n;
   endfunction

   function automatic logic model_busy();
      return (seq_st != PH_IDLE) || ack_low_pending;
   endfunction

   // Only an idle sequencer takes a command; each command sets up the first
   // line levels of its sequence at once.
   function automatic void start_sequence(input cmd_type cmd, input logic [7:0] txb);
      case (cmd)
         CMD_START: begin
            sda_q = 1'b1; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_START_B;
         end
         CMD_STOP: begin
            sda_q = 1'b0; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_STOP_B;
         end
         CMD_WRITE: begin
            shifter = txb; bit_idx = '0; sda_q = txb[7];
            ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_WR_HIGH;
         end
         CMD_READ: begin
            shifter = '0; bit_idx = '0; sda_q = 1'b1;
            ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_RD_HIGH;
         end
         CMD_WAIT_ACK: begin
            ack_q = 1'b0; to_cnt = '0; sda_q = 1'b1;
            ph_cnt = ticks_of(cfg.ack_phase_ticks); seq_st = PH_ACK_HIGH;
         end
         CMD_ACK: begin
            scl_q = 1'b0; sda_q = 1'b0; bit_idx = '0;
            ph_cnt = ticks_of(cfg.ack_phase_ticks); seq_st = PH_GEN_HIGH;
         end
         CMD_NACK: begin
            sda_q = 1'b1; bit_idx = 4'd1;
            ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_GEN_HIGH;
         end
         default: ;
      endcase
   endfunction

   // One look at SDA while SCL is high. Low means acknowledged. High past
   // the tolerated count flags the missing ack and turns into a stop.
   function automatic logic poll_ack(input logic sda);
      if (!sda) begin
         scl_q = 1'b0;
         return 1'b1;
      end
      if (to_cnt >= cfg.ack_timeout) begin
         ack_q  = 1'b1;
         sda_q  = 1'b0;
         ph_cnt = ticks_of(cfg.phase_ticks);
         seq_st = PH_STOP_B;
      end else begin
         to_cnt = to_cnt + 16'd1;
      end
      return 1'b0;
   endfunction

   // The step due when the wait of the current phase runs out. Returns one
   // when the command is complete.
   function automatic logic finish_phase(input logic sda);
      case (seq_st)
         PH_START_B: begin
            scl_q = 1'b1; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_START_C;
         end
         PH_START_C: begin
            sda_q = 1'b0; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_START_D;
         end
         PH_START_D: begin
            scl_q = 1'b0; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_START_E;
         end
         PH_STOP_B: begin
            scl_q = 1'b1; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_STOP_C;
         end
         PH_STOP_C: begin
            sda_q = 1'b1; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_STOP_D;
         end
         PH_WR_HIGH: begin
            scl_q = 1'b1; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_WR_LOW;
         end
         PH_WR_LOW: begin
            scl_q = 1'b0; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_WR_NEXT;
         end
         PH_WR_NEXT: begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= 4'd8) return 1'b1;
            shifter = shifter << 1;
            sda_q   = shifter[7];
            ph_cnt  = ticks_of(cfg.phase_ticks);
            seq_st  = PH_WR_HIGH;
         end
         PH_RD_HIGH: begin
            if (bit_idx >= 4'd8) begin
               rx_hold = shifter;
               return 1'b1;
            end
            scl_q = 1'b1; ph_cnt = ticks_of(cfg.phase_ticks); seq_st = PH_RD_SAMPLE;
         end
         PH_RD_SAMPLE: begin
            if (sda) shifter = shifter | (8'h80 >> bit_idx[2:0]);
            scl_q   = 1'b0;
            bit_idx = bit_idx + 4'd1;
            ph_cnt  = ticks_of(cfg.phase_ticks);
            seq_st  = PH_RD_HIGH;
         end
         PH_ACK_HIGH: begin
            scl_q = 1'b1; ph_cnt = ticks_of(cfg.ack_high_ticks); seq_st = PH_ACK_POLL;
         end
         PH_GEN_HIGH: begin
            // Nack holds SCL high for a normal phase, ack for an ack phase.
            scl_q  = 1'b1;
            ph_cnt = ticks_of((bit_idx != 4'd0) ? cfg.phase_ticks : cfg.ack_phase_ticks);
            ack_low_pending = 1'b1;
            seq_st = PH_IDLE;
         end
         default: return 1'b1;  // last wait of start or stop
      endcase
      return 1'b0;
   endfunction

   // Advances the predictor by one tick and returns the levels and flags
   // the block must report for it.
   function automatic result_type step_bus_levels(input cmd_type cmd,
                                                  input logic [7:0] txb,
                                                  input logic sda);
      logic       fin;
      result_type r;
      fin = 1'b0;
      if (ack_low_pending) begin
         ph_cnt = ph_cnt - 16'd1;
         if (ph_cnt == '0) begin
            scl_q = 1'b0;
            ack_low_pending = 1'b0;
            fin = 1'b1;
         end
      end else if (seq_st == PH_IDLE) begin
         start_sequence(cmd, txb);
      end else if (seq_st == PH_ACK_POLL && ph_cnt == '0) begin
         fin = poll_ack(sda);
      end else begin
         ph_cnt = ph_cnt - 16'd1;
         if (ph_cnt == '0)
            fin = (seq_st == PH_ACK_POLL) ? poll_ack(sda) : finish_phase(sda);
      end
      if (fin) begin
         seq_st = PH_IDLE;
         ph_cnt = '0;
      end
      r.scl_level   = scl_q;
      r.sda_release = sda_q;
      r.busy_res    = model_busy();
      r.done_res    = fin;
      r.rx_byte     = rx_hold;
      r.ack_missing = ack_q;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: the receiver drives rsp_tready on the falling edge and
   // the checker compares every accepted item on the rising edge.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int exp_v, input int got_v);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns: %s expected %0h, got %0h", $time, what, exp_v, got_v);
   endtask

   int unsigned hold_left = 0;

   always @(negedge clock) begin
      if (hold_pending) begin
         hold_left    = RSP_HOLD_CYCLES;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(gaps_on && $urandom_range(99) < 6);
      end
   end

   always @(posedge clock) begin : check_levels
      result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch("item with nothing expected", 0, rsp_tdata);
         end else begin
            e = expected_levels.pop_front();
            if (rsp_tdata[0] !== e.scl_level)
               report_mismatch("scl_level", e.scl_level, rsp_tdata[0]);
            if (rsp_tdata[1] !== e.sda_release)
               report_mismatch("sda_release", e.sda_release, rsp_tdata[1]);
            if (rsp_tdata[2] !== e.busy_res)
               report_mismatch("busy_res", e.busy_res, rsp_tdata[2]);
            if (rsp_tdata[3] !== e.done_res)
               report_mismatch("done_res", e.done_res, rsp_tdata[3]);
            if (rsp_tdata[11:4] !== e.rx_byte)
               report_mismatch("rx_byte", e.rx_byte, rsp_tdata[11:4]);
            if (rsp_tdata[12] !== e.ack_missing)
               report_mismatch("ack_missing", e.ack_missing, rsp_tdata[12]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Input side. Every task below starts and ends on a falling edge. The
   // tick task leaves req_tvalid high so that back-to-back items never
   // lower and raise it within one time step.
   // ---------------------------------------------------------------------
   task automatic send_tick(input cmd_type cmd, input logic [7:0] txb, input logic sda);
      while (gaps_on && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, sda, txb};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_levels.push_back(step_bus_levels(cmd, txb, sda));
      @(negedge clock);
   endtask

   // Stops offering items and waits until every expected item has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_levels.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [DELAY_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // All four delay registers are written with the input side quiet. The
   // sequencer may still be inside a sequence; new values apply from the
   // next phase that loads them, on both sides alike.
   task automatic set_delays(input logic [DELAY_W-1:0] p, input logic [DELAY_W-1:0] a,
                             input logic [DELAY_W-1:0] h, input logic [DELAY_W-1:0] t);
      drain_results();
      write_reg(CSR_PHASE_TICKS, p);
      write_reg(CSR_ACK_PHASE_TICKS, a);
      write_reg(CSR_ACK_HIGH_TICKS, h);
      write_reg(CSR_ACK_TIMEOUT, t);
   endtask

   // Waits out any running sequence, issues one command, then ticks until
   // it is complete. Each busy tick carries busy_cmd, which must be ignored.
   task automatic run_command(input cmd_type cmd, input logic [7:0] txb,
                              input logic sda, input cmd_type busy_cmd);
      while (model_busy())
         send_tick(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      send_tick(cmd, txb, sda);
      while (model_busy())
         send_tick(busy_cmd, 8'($urandom_range(255)), sda);
   endtask

   // One well-formed transfer: start, address, ack, a few data bytes in
   // either direction, stop.
   function automatic void plan_transaction();
      int n;
      plan.push_back(CMD_START);
      plan.push_back(CMD_WRITE);
      plan.push_back(CMD_WAIT_ACK);
      n = $urandom_range(3, 1);
      repeat (n) begin
         if ($urandom_range(1)) begin
            plan.push_back(CMD_WRITE);
            plan.push_back(CMD_WAIT_ACK);
         end else begin
            plan.push_back(CMD_READ);
            plan.push_back($urandom_range(1) ? CMD_ACK : CMD_NACK);
         end
      end
      plan.push_back(CMD_STOP);
   endfunction

   // Mostly well-formed transfers with random bytes and SDA, and now and
   // then a stray command, both while idle (out of order) and while busy.
   // During a wait ack the slave holds SDA high for a random number of
   // ticks, sometimes long enough to run into the timeout.
   task automatic run_random_traffic(input int n_ticks);
      cmd_type    cmd;
      logic [7:0] txb;
      logic       sda;
      int         k;
      for (k = 0; k < n_ticks; k++) begin
         txb = 8'($urandom_range(255));
         if (!model_busy()) begin
            if (plan.size() == 0) plan_transaction();
            if ($urandom_range(99) < 12) cmd = cmd_type'($urandom_range(7));
            else cmd = plan.pop_front();
            if (cmd == CMD_WAIT_ACK)
               sda_high_left = $urandom_range(int'(cfg.ack_phase_ticks)
                  + int'(cfg.ack_high_ticks) + int'(cfg.ack_timeout) + 3);
            else
               sda_high_left = -1;
         end else begin
            cmd = ($urandom_range(99) < 8) ? cmd_type'($urandom_range(7)) : CMD_NONE;
         end
         if (sda_high_left >= 0) begin
            sda = (sda_high_left > 0);
            if (sda_high_left > 0) sda_high_left--;
         end else begin
            sda = 1'($urandom_range(1));
         end
         send_tick(cmd, txb, sda);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Traffic at the delays that reset leaves behind.
   task automatic test_reset_delays();
      run_random_traffic(200);
   endtask

   // Every command at least once, first with all delays at zero, so each phase is
   // one tick. Busy ticks carry commands that must be ignored, including on
   // the tick a sequence completes. The unused register index is written too.
   task automatic test_directed();
      set_delays('0, '0, '0, '0);
      write_reg(CSR_UNUSED_INDEX, 16'h0007);
      write_reg(CSR_TOP_INDEX, 16'hFFFF);
      run_command(CMD_START, 8'h00, 1'b1, CMD_STOP);
      run_command(CMD_WRITE, 8'hFF, 1'b1, CMD_WRITE);
      run_command(CMD_WRITE, 8'h00, 1'b0, CMD_READ);
      run_command(CMD_WRITE, 8'hA5, 1'b0, CMD_NONE);
      run_command(CMD_WAIT_ACK, 8'h00, 1'b0, CMD_START);   // acked at the first poll
      run_command(CMD_WAIT_ACK, 8'hFF, 1'b1, CMD_NONE);    // zero timeout: first high poll
      run_command(CMD_READ, 8'h00, 1'b1, CMD_ACK);
      run_command(CMD_READ, 8'hFF, 1'b0, CMD_NACK);
      run_command(CMD_ACK, 8'h00, 1'b1, CMD_WAIT_ACK);
      run_command(CMD_NACK, 8'h00, 1'b0, CMD_WRITE);
      run_command(CMD_STOP, 8'h00, 1'b1, CMD_NONE);
      run_command(CMD_NONE, 8'h00, 1'b0, CMD_NONE);
      set_delays('0, 16'd1, 16'd1, 16'd2);
      run_command(CMD_WAIT_ACK, 8'h00, 1'b1, CMD_NONE);    // times out after a few polls
      run_command(CMD_WAIT_ACK, 8'h00, 1'b0, CMD_NONE);    // and clears the flag again
   endtask

   // Several short-delay settings; one round runs without any idling.
   task automatic test_random_settings();
      int r;
      for (r = 0; r < 4; r++) begin
         set_delays(16'($urandom_range(4, 1)), 16'($urandom_range(3, 1)),
                    16'($urandom_range(3, 1)), 16'($urandom_range(4)));
         gaps_on = (r != 2);
         run_random_traffic(160);
      end
      gaps_on = 1'b1;
   endtask

   // The receiver holds off long enough for the block to fill and stall
   // its input while items keep being offered.
   task automatic test_backpressure();
      set_delays(16'd2, 16'd1, 16'd2, 16'd3);
      hold_pending = 1'b1;
      run_random_traffic(150);
   endtask

   // The sender pauses mid-traffic until every expected item has arrived.
   task automatic test_sender_pause();
      run_random_traffic(100);
      drain_results();
      run_random_traffic(100);
   endtask

   // Largest delays: the counters load the full register values and count
   // down for a few dozen ticks of a wait ack, with stray commands ignored.
   // A full phase at this length is far beyond the run, so it is not waited
   // out. No idling here.
   task automatic test_max_delays();
      gaps_on = 1'b0;
      while (model_busy())
         send_tick(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      set_delays(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(CMD_WAIT_ACK, 8'($urandom_range(255)), 1'b1);
      repeat (48)
         send_tick(cmd_type'($urandom_range(7)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      gaps_on = 1'b1;
   endtask

   initial begin
      reset_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_delays();
      test_directed();
      test_random_settings();
      test_backpressure();
      test_sender_pause();
      test_max_delays();

      drain_results();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
